>>> sv/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// iplpm_pkg: shared types and constants of the IPv4 longest prefix router
// Field widths, status and operation codes, sequencer states, the route
// table entry layout and the prefix mask function.
// ----------------------------------------------------------------------------
package iplpm_pkg;

   localparam int unsigned ADDR_W          = 32;
   localparam int unsigned LEN_W           = 6;
   localparam int unsigned IFC_W           = 2;
   localparam int unsigned TTL_W           = 8;
   localparam int unsigned STATUS_W        = 2;
   localparam int unsigned INTERFACE_COUNT = 4;

   // Stream payload widths, padded to whole bytes.
   localparam int unsigned REQ_TDATA_W = 120;
   localparam int unsigned RSP_TDATA_W = 48;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ROUTE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_FORWARD     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TTL_EXPIRED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROUTE    = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN,
      SEQ_FINISH
   } seq_state_type;

   // One stored route: key and action together in one memory word.
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [IFC_W-1:0]  iface;
   } route_entry_type;

   // Sequencer commands to the compare unit and the result register.
   typedef struct packed {
      logic clear;
      logic cmp_en;
      logic load_rsp;
   } seq_ctrl_type;

   // Best match held by the compare unit.
   typedef struct packed {
      logic              found;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [IFC_W-1:0]  iface;
   } match_result_type;

   // Leading-ones mask of the given length; length 0 gives no bits.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

>>> sv/iplpm_ram.sv
// ----------------------------------------------------------------------------
// iplpm_ram: generic single write port, single read port memory
// Read data is registered; contents are undefined until written.
// ----------------------------------------------------------------------------
module iplpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/iplpm_match.sv
// ----------------------------------------------------------------------------
// iplpm_match: shared prefix compare unit
// Compares one table entry per cycle with the destination and keeps the
// longest hit so far, a later entry winning on equal length.
// ----------------------------------------------------------------------------
module iplpm_match (
   input  logic                        clock,
   input  logic                        reset,
   input  iplpm_pkg::seq_ctrl_type     ctrl,
   input  logic [31:0]                 dst,
   input  iplpm_pkg::route_entry_type  entry,
   output iplpm_pkg::match_result_type best
);

   import iplpm_pkg::*;

   logic                found_ff, found_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   route_entry_type     best_ff, best_in;
   logic                hit;

   assign hit = (entry.length == '0) ||
                (entry.prefix == (dst & prefix_mask(entry.length)));

   always_comb begin
      found_in    = found_ff;
      best_len_in = best_len_ff;
      best_in     = best_ff;
      if (ctrl.clear) begin
         found_in    = 1'b0;
         best_len_in = '0;
      end else if (ctrl.cmp_en && hit && (entry.length >= best_len_ff)) begin
         found_in    = 1'b1;
         best_len_in = entry.length;
         best_in     = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         best_len_ff <= '0;
      end else begin
         found_ff    <= found_in;
         best_len_ff <= best_len_in;
      end
      best_ff <= best_in;
   end

   assign best.found   = found_ff;
   assign best.has_hop = best_ff.has_hop;
   assign best.hop     = best_ff.hop;
   assign best.iface   = best_ff.iface;

endmodule

>>> sv/iplpm_seq.sv
// ----------------------------------------------------------------------------
// iplpm_seq: route table sequencer
// Keeps the route count, writes added routes and steps the read address
// over the valid entries for each lookup whose TTL has not expired.
// ----------------------------------------------------------------------------
module iplpm_seq #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_op,
   input  logic                         ifc_ok,
   input  logic                         expired,
   input  logic                         rsp_pending,
   input  logic                         rsp_tready,
   output logic                         req_tready,
   output logic                         wr_en,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
   output iplpm_pkg::seq_ctrl_type      ctrl
);

   import iplpm_pkg::*;

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rd_en_ff, rd_en;
   logic              accept;
   logic              last_idx;
   logic              table_full;

   assign accept     = req_tvalid && req_tready;
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign last_idx   = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept && (req_op == OP_ROUTE)) begin
               if (expired || (count_ff == '0)) begin
                  state_in = SEQ_FINISH;
               end else begin
                  state_in = SEQ_SCAN;
               end
            end
         end
         SEQ_SCAN: begin
            if (last_idx) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_FINISH;
         end
         SEQ_FINISH: begin
            if (!rsp_pending || rsp_tready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Outputs and counters.
   always_comb begin
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      ctrl.clear    = 1'b0;
      ctrl.cmp_en   = rd_en_ff;
      ctrl.load_rsp = 1'b0;
      count_in      = count_ff;
      idx_in        = idx_ff;
      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            idx_in     = '0;
            if (accept) begin
               if (req_op == OP_ADD) begin
                  if (ifc_ok && !table_full) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  ctrl.clear = 1'b1;
               end
            end
         end
         SEQ_SCAN: begin
            rd_en = 1'b1;
            if (!last_idx) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         SEQ_DRAIN: begin
            rd_en = 1'b0;
         end
         SEQ_FINISH: begin
            ctrl.load_rsp = !rsp_pending || rsp_tready;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign wr_addr     = count_ff[IDX_W-1:0];
   assign rd_addr     = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         rd_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         rd_en_ff <= rd_en;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count exceeds table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SCAN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond valid entries");

   a_no_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == SEQ_IDLE) && !table_full)
      else $error("table write outside idle or into a full table");
`endif

endmodule

>>> sv/ipv4_longest_prefix_router_unit.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router_unit: IPv4 longest prefix match forwarder
// Holds a route table in memory and resolves datagram destinations to an
// outgoing interface and forwarding address by walking the table.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Ports                          | Carries
//   req     | in        | req_tvalid/tready/tdata/tuser  | add-route or route items
//   rsp     | out       | rsp_tvalid/tready/tdata/tuser  | one result per route item
//
// An add item with a valid interface writes the next free table entry unless
// the table is full. A route item is accepted, then the single compare unit
// checks each stored route as it is read from the table memory, a drain
// state lets the last read land, and a finish state loads the result
// register. An expired TTL or an empty table skips the walk.
// Reset is synchronous and active high; it empties the table (the memory
// itself is never cleared, only the route count). While a result waits for
// rsp_tready the block still takes new items, and a lookup that finishes
// before the old result is taken holds until the result register frees up.
//
module ipv4_longest_prefix_router_unit #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] prefix, [37:32] prefix length, [38] has_next_hop,
   // [70:39] next_hop_address, [72:71] interface_number,
   // [104:73] destination_address, [112:105] ttl_in, [119:113] zero
   input  logic [iplpm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] operation
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] out_interface, [33:2] forward_address, [41:34] ttl_out,
   // [47:42] zero
   output logic [iplpm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [iplpm_pkg::STATUS_W-1:0]        rsp_tuser
);

   import iplpm_pkg::*;

   localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned ENTRY_W = $bits(route_entry_type);

   // Unpacked request fields.
   logic              f_op;
   logic [ADDR_W-1:0] f_prefix;
   logic [LEN_W-1:0]  f_len;
   logic              f_has_hop;
   logic [ADDR_W-1:0] f_hop;
   logic [IFC_W-1:0]  f_ifc;
   logic [ADDR_W-1:0] f_dst;
   logic [TTL_W-1:0]  f_ttl;

   assign f_op      = req_tuser[0];
   assign f_prefix  = req_tdata[31:0];
   assign f_len     = req_tdata[37:32];
   assign f_has_hop = req_tdata[38];
   assign f_hop     = req_tdata[70:39];
   assign f_ifc     = req_tdata[72:71];
   assign f_dst     = req_tdata[104:73];
   assign f_ttl     = req_tdata[112:105];

   logic [TTL_W-1:0]  ttl_dec;
   logic              expired;
   logic              ifc_ok;
   route_entry_type   wr_entry;
   route_entry_type   rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   seq_ctrl_type      ctrl;
   match_result_type  best;
   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;

   // A TTL of zero stays zero; the datagram dies if the result is zero.
   assign ttl_dec = (f_ttl == '0) ? '0 : (f_ttl - TTL_W'(1));
   assign expired = (ttl_dec == '0);
   assign ifc_ok  = (32'(f_ifc) < INTERFACE_COUNT);
   assign accept  = req_tvalid && req_tready;

   // Lengths above the address width are saturated when stored.
   always_comb begin
      wr_entry.prefix  = f_prefix;
      wr_entry.length  = (f_len > MAX_LEN) ? MAX_LEN : f_len;
      wr_entry.has_hop = f_has_hop;
      wr_entry.hop     = f_hop;
      wr_entry.iface   = f_ifc;
   end

   assign rd_entry = route_entry_type'(rd_word);

   // Datagram context captured at acceptance of a route item.
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [TTL_W-1:0]  ttl_ff, ttl_in;
   logic              expired_ff, expired_in;

   always_comb begin
      dst_in     = dst_ff;
      ttl_in     = ttl_ff;
      expired_in = expired_ff;
      if (accept && (f_op == OP_ROUTE)) begin
         dst_in     = f_dst;
         ttl_in     = ttl_dec;
         expired_in = expired;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff     <= dst_in;
      ttl_ff     <= ttl_in;
      expired_ff <= expired_in;
   end

   iplpm_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_op      (f_op),
      .ifc_ok      (ifc_ok),
      .expired     (expired),
      .rsp_pending (rsp_valid_ff),
      .rsp_tready  (rsp_tready),
      .req_tready  (req_tready),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .ctrl        (ctrl)
   );

   iplpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   iplpm_match u_match (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .dst   (dst_ff),
      .entry (rd_entry),
      .best  (best)
   );

   // Result register, reloaded only once the previous result is taken.
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IFC_W-1:0]    iface_ff, iface_in;
   logic [ADDR_W-1:0]   fwd_ff, fwd_in;
   logic [TTL_W-1:0]    ttl_out_ff, ttl_out_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      iface_in     = iface_ff;
      fwd_in       = fwd_ff;
      ttl_out_in   = ttl_out_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (expired_ff) begin
            status_in  = ST_TTL_EXPIRED;
            iface_in   = '0;
            fwd_in     = '0;
            ttl_out_in = '0;
         end else if (!best.found) begin
            status_in  = ST_NO_ROUTE;
            iface_in   = '0;
            fwd_in     = '0;
            ttl_out_in = ttl_ff;
         end else begin
            status_in  = ST_FORWARD;
            iface_in   = best.iface;
            fwd_in     = best.has_hop ? best.hop : dst_ff;
            ttl_out_in = ttl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      iface_ff   <= iface_in;
      fwd_ff     <= fwd_in;
      ttl_out_ff <= ttl_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'b0, ttl_out_ff, fwd_ff, iface_ff};

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register reloaded while a result still waits");

   a_lookup_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmp_en || ctrl.load_rsp) |-> !req_tready)
      else $error("input taken while a lookup is in progress");

   a_expired_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_TTL_EXPIRED)) |-> (rsp_tdata == '0))
      else $error("expired result carries nonzero fields");
`endif

endmodule

>>> tb/sv/ipv4_lpm_route_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_lpm_route_checker: scoreboard for the IPv4 longest prefix router
// Watches both stream channels, keeps its own copy of the route table,
// predicts the result of every route item and compares it field by field.
// ----------------------------------------------------------------------------
module ipv4_lpm_route_checker #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [iplpm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]                        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [iplpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [iplpm_pkg::STATUS_W-1:0]    rsp_tuser,
   output int                                fail_count,
   output int                                pending_count,
   output int                                forwarded_count,
   output int                                dropped_count,
   output int                                unrouted_count
);

   import iplpm_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [IFC_W-1:0]  iface;
   } stored_route_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IFC_W-1:0]    iface;
      logic [ADDR_W-1:0]   forward_addr;
      logic [TTL_W-1:0]    ttl;
   } forward_decision_type;

   stored_route_type     routes [TABLE_DEPTH];
   int                   route_total = 0;
   int                   mismatches = 0;
   forward_decision_type expected_decisions [$];

   // Walks the table in order; a later entry of equal length takes over.
   function automatic forward_decision_type decide_forwarding(
      input logic [ADDR_W-1:0] dst,
      input logic [TTL_W-1:0]  ttl);
      forward_decision_type d;
      logic [TTL_W-1:0]  ttl_left;
      logic [ADDR_W-1:0] mask;
      logic [LEN_W-1:0]  best_len;
      int                best;
      d        = '0;
      best     = -1;
      best_len = '0;
      ttl_left = (ttl != '0) ? ttl - 1'b1 : ttl;
      if (ttl_left == '0) begin
         d.status = ST_TTL_EXPIRED;
         return d;
      end
      for (int i = 0; i < route_total; i++) begin
         mask = {ADDR_W{1'b1}} << (ADDR_W - routes[i].length);
         if ((routes[i].length == '0 || routes[i].prefix == (dst & mask)) &&
             routes[i].length >= best_len) begin
            best     = i;
            best_len = routes[i].length;
         end
      end
      d.ttl = ttl_left;
      if (best < 0) begin
         d.status = ST_NO_ROUTE;
      end else begin
         d.status       = ST_FORWARD;
         d.iface        = routes[best].iface;
         d.forward_addr = routes[best].has_hop ? routes[best].hop : dst;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      forward_decision_type seen;
      forward_decision_type want;
      stored_route_type     entry;
      if (reset) begin
         route_total = 0;
         expected_decisions.delete();
      end else begin
         // Results are checked before new requests are predicted: a result
         // taken at this edge always belongs to an earlier item.
         if (rsp_tvalid && rsp_tready) begin
            seen.status       = rsp_tuser;
            seen.iface        = rsp_tdata[1:0];
            seen.forward_addr = rsp_tdata[33:2];
            seen.ttl          = rsp_tdata[41:34];
            if (expected_decisions.size() == 0) begin
               $error("result with nothing expected: status %0d, forward_address %h",
                      seen.status, seen.forward_addr);
               mismatches++;
            end else begin
               want = expected_decisions.pop_front();
               if (seen.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, seen.status);
                  mismatches++;
               end
               if (seen.iface != want.iface) begin
                  $error("out_interface: expected %0d, actual %0d", want.iface, seen.iface);
                  mismatches++;
               end
               if (seen.forward_addr != want.forward_addr) begin
                  $error("forward_address: expected %h, actual %h",
                         want.forward_addr, seen.forward_addr);
                  mismatches++;
               end
               if (seen.ttl != want.ttl) begin
                  $error("ttl_out: expected %0d, actual %0d", want.ttl, seen.ttl);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_ADD) begin
               entry.prefix  = req_tdata[31:0];
               entry.length  = req_tdata[37:32];
               entry.has_hop = req_tdata[38];
               entry.hop     = req_tdata[70:39];
               entry.iface   = req_tdata[72:71];
               if (entry.length > MAX_LEN)
                  entry.length = MAX_LEN;
               if (route_total < TABLE_DEPTH && entry.iface < INTERFACE_COUNT) begin
                  routes[route_total] = entry;
                  route_total++;
               end
            end else begin
               want = decide_forwarding(req_tdata[104:73], req_tdata[112:105]);
               expected_decisions.insert(expected_decisions.size(), want);
               if (want.status == ST_FORWARD)
                  forwarded_count <= forwarded_count + 1;
               else if (want.status == ST_TTL_EXPIRED)
                  dropped_count <= dropped_count + 1;
               else
                  unrouted_count <= unrouted_count + 1;
            end
         end
      end
      pending_count <= expected_decisions.size();
      fail_count    <= mismatches;
   end

endmodule

>>> tb/sv/tb_ipv4_longest_prefix_router_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_longest_prefix_router_unit: testbench of the IPv4 prefix router
// Drives add and route items with random gaps and result back-pressure, and
// lets the route checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb_ipv4_longest_prefix_router_unit;
   import iplpm_pkg::*;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 600;
   // The drain wait covers a full-table lookup with some slack once the last
   // result has been taken.
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   // The slowest correct run is about 650 items, each paying a full-table
   // lookup, the longest sender gap and the longest receiver stall. The limit
   // sits well above that.
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
   } known_net_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [31:0] prefix, [37:32] prefix length, [38] has_next_hop,
   // [70:39] next_hop_address, [72:71] interface_number,
   // [104:73] destination_address, [112:105] ttl_in, [119:113] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] operation
   logic [0:0]             req_tuser = OP_ADD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [1:0] out_interface, [33:2] forward_address, [41:34] ttl_out,
   // [47:42] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [STATUS_W-1:0]    rsp_tuser;

   int mismatches;
   int pending;
   int forwarded;
   int dropped;
   int unrouted;
   int cycle_count = 0;
   int adds_sent = 0;
   int lookups_sent = 0;
   int burst_left = 0;
   int ready_hold = 0;

   // Networks that made it into the table. Random destinations are mostly
   // drawn from inside them so that lookups hit real routes.
   known_net_type known_nets [$];

   ipv4_longest_prefix_router_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   ipv4_lpm_route_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) route_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (mismatches),
      .pending_count  (pending),
      .forwarded_count(forwarded),
      .dropped_count  (dropped),
      .unrouted_count (unrouted)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a run that hangs, or leaves results outstanding, fails here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Cycle limit of %0d reached with %0d results outstanding",
                  CYCLE_LIMIT, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result back-pressure. Each decision holds for a number of cycles: long
   // stretches of steady ready, long stalls now and then, and otherwise short
   // random stalls mixed with single ready cycles.
   always @(posedge clock) begin
      int pick;
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(30, 200);
         end else if (pick < 12) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 60);
         end else if (pick < 40) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Leading-ones mask of a prefix length, with lengths past 32 treated as 32
   // the way the block stores them.
   function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] bits;
      bits = (len > MAX_LEN) ? MAX_LEN : len;
      return {ADDR_W{1'b1}} << (ADDR_W - bits);
   endfunction

   // Idle cycles after an item. Bursts of back-to-back items come now and
   // then; otherwise gaps are mostly short with a few long ones.
   function automatic int pick_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      if (pick < 55)
         return 0;
      if (pick < 88)
         return $urandom_range(1, 3);
      if (pick < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Presents one item and holds it until the block takes it. Every call
   // starts just after a rising edge, so valid stays high between items that
   // follow each other without a gap.
   task automatic push_item(input logic op, input logic [REQ_TDATA_W-1:0] data);
      int gap;
      req_tuser  <= op;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Fields that an add does not use carry random values all the same.
   task automatic send_add(input logic [ADDR_W-1:0] prefix, input logic [LEN_W-1:0] len,
                           input logic has_hop, input logic [ADDR_W-1:0] hop,
                           input logic [IFC_W-1:0] iface);
      known_net_type net;
      push_item(OP_ADD, {7'd0, TTL_W'($urandom), ADDR_W'($urandom), iface, hop, has_hop,
                         len, prefix});
      adds_sent++;
      if (adds_sent <= TABLE_DEPTH) begin
         net.prefix = prefix;
         net.length = len;
         known_nets.insert(known_nets.size(), net);
      end
   endtask

   task automatic route_packet(input logic [ADDR_W-1:0] dst, input logic [TTL_W-1:0] ttl);
      push_item(OP_ROUTE, {7'd0, ttl, dst, IFC_W'($urandom), ADDR_W'($urandom),
                           1'($urandom), LEN_W'($urandom), ADDR_W'($urandom)});
      lookups_sent++;
   endtask

   // Random route: a common length, an oversized one, or any length, on a
   // prefix that is either carved out of a known network (nested routes),
   // fresh and properly masked, or raw with host bits left set.
   task automatic random_add();
      int                pick;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] base;
      known_net_type     net;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         len = LEN_W'($urandom_range(0, 4) * 8);
      else if (pick < 30)
         len = LEN_W'($urandom_range(33, 63));
      else
         len = LEN_W'($urandom_range(0, 32));
      pick = $urandom_range(0, 99);
      if (pick < 50 && known_nets.size() > 0) begin
         net  = known_nets[$urandom_range(0, known_nets.size() - 1)];
         base = (net.prefix & net_mask(net.length)) | ($urandom() & ~net_mask(net.length));
         base = base & net_mask(len);
      end else if (pick < 80) begin
         base = $urandom() & net_mask(len);
      end else begin
         base = $urandom();
      end
      send_add(base, len, 1'($urandom), $urandom(), IFC_W'($urandom));
   endtask

   // Random lookup: mostly a destination inside a known network, with TTLs
   // of 0, 1 and 2 showing up often enough to hit the expiry paths.
   task automatic random_lookup();
      int                pick;
      known_net_type     net;
      logic [ADDR_W-1:0] dst;
      logic [TTL_W-1:0]  ttl;
      if (known_nets.size() > 0 && $urandom_range(0, 99) < 75) begin
         net = known_nets[$urandom_range(0, known_nets.size() - 1)];
         dst = (net.prefix & net_mask(net.length)) | ($urandom() & ~net_mask(net.length));
      end else begin
         dst = $urandom();
      end
      pick = $urandom_range(0, 99);
      if (pick < 4)
         ttl = 8'd0;
      else if (pick < 8)
         ttl = 8'd1;
      else if (pick < 11)
         ttl = 8'd2;
      else
         ttl = TTL_W'($urandom);
      route_packet(dst, ttl);
   endtask

   initial begin
      int counted;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lookups on an empty table: no route, and both ways a TTL expires.
      route_packet(32'h0A01_0203, 8'd5);
      route_packet(32'h0A01_0203, 8'd0);
      route_packet(32'h0A01_0203, 8'd1);

      // A default route, a direct host route at the top of the address space,
      // nested /8, /16 and /24 networks, two /16 entries for the same network
      // where the later one must win, an oversized length that the block
      // clamps to 32, and a /16 whose stored prefix keeps host bits and so can
      // never match.
      send_add(32'h0000_0000, 6'd0, 1'b1, 32'hC0A8_0001, 2'd3);
      send_add(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h1234_5678, 2'd0);
      send_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_00FE, 2'd1);
      send_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 2'd2);
      send_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A01_00FE, 2'd1);
      send_add(32'hC0A8_0101, 6'd63, 1'b1, 32'hAC10_0001, 2'd2);
      send_add(32'h0A02_0001, 6'd16, 1'b1, 32'h0101_0101, 2'd0);
      send_add(32'h0A01_0200, 6'd24, 1'b0, 32'h0000_0000, 2'd3);

      // Lookups that land on each of those routes that can win, with TTL extremes.
      route_packet(32'h0A01_0203, 8'd255);
      route_packet(32'h0A01_63FF, 8'd64);
      route_packet(32'h0A02_0001, 8'd2);
      route_packet(32'hC0A8_0101, 8'd128);
      route_packet(32'hFFFF_FFFF, 8'd200);
      route_packet(32'h0102_0304, 8'd9);

      // Random part: mostly lookups, with adds that fill the table and then
      // keep arriving at a full one. Adds past a full table do nothing and
      // are not counted.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 8) begin
            random_add();
            if (adds_sent <= TABLE_DEPTH)
               counted++;
         end else begin
            random_lookup();
            counted++;
         end
      end
      req_tvalid <= 1'b0;

      // Let the count of outstanding results catch up with the last item
      // before it is trusted, then wait for it to drain.
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d lookups (%0d forwarded, %0d dropped on TTL, %0d without a route)",
               lookups_sent, forwarded, dropped, unrouted);
      $display("and %0d route adds, %0d of them against a full table.",
               adds_sent, (adds_sent > TABLE_DEPTH) ? adds_sent - TABLE_DEPTH : 0);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
